// ===== rtl/qav_pkg.sv =====
// qav_pkg: shared constants and tables for the quaternion angular velocity unit
// no dependencies; used by quaternion_angular_velocity_unit and qav_checker
package qav_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;

    localparam int IN_W  = 16;
    localparam int CFG_W = 20;
    localparam int OUT_W = 32;

    localparam logic [CFG_W-1:0] PERIOD_RESET = 20'd1000;

    localparam int SQRT_N   = 31;
    localparam int CORDIC_N = 30;
    localparam int DIV_N    = 32;

    // q2.30 constants
    localparam logic [30:0] ONE30     = 31'h4000_0000;
    localparam logic [31:0] HALF_PI30 = 32'd1686629713;

    // us to s scale and the q16.16 alignment shift
    localparam logic [CFG_W-1:0] RATE_SCALE = 20'd1000000;
    localparam int RATE_SHIFT = 14;

    localparam logic signed [OUT_W-1:0] RATE_MAX = 32'sh7fff_ffff;
    localparam logic signed [OUT_W-1:0] RATE_MIN = 32'sh8000_0000;

    // atan(2^-i) in q.30
    localparam logic [31:0] ATAN_Q30 [CORDIC_N] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

endpackage

// ===== rtl/quaternion_angular_velocity_unit.sv =====
// quaternion_angular_velocity_unit: mean angular rate between two orientation quaternions
// depends on qav_pkg (constants, arctangent table)
//
//   channel   direction  handshake             word
//   in        to block   in_valid / in_stall   first_*, second_*, force_shortest
//   out       from block out_valid / out_stall rate_x, rate_y, rate_z, saturated
//   cfg       to block   cfg_wr_en             cfg_wr_data (sample period, us)
//
// one word per cycle in and out while in_stall and out_stall are low; the 31-step square root,
//   the 30-step cordic arctangent and the 32-step divider run one step per stage
// rst_n clears all valid bits, including the output and skid slots, and sets the period to 1000 us
// a stall on out freezes nothing at first: the word parks in the skid slot,
//   which raises in_stall, and the whole pipeline holds until the output drains
module quaternion_angular_velocity_unit #(
    parameter int QUAT_FRAC_BITS = qav_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [qav_pkg::IN_W-1:0] first_x,
    input  logic signed [qav_pkg::IN_W-1:0] first_y,
    input  logic signed [qav_pkg::IN_W-1:0] first_z,
    input  logic signed [qav_pkg::IN_W-1:0] first_w,
    input  logic signed [qav_pkg::IN_W-1:0] second_x,
    input  logic signed [qav_pkg::IN_W-1:0] second_y,
    input  logic signed [qav_pkg::IN_W-1:0] second_z,
    input  logic signed [qav_pkg::IN_W-1:0] second_w,
    input  logic                            force_shortest,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [qav_pkg::OUT_W-1:0] rate_x,
    output logic signed [qav_pkg::OUT_W-1:0] rate_y,
    output logic signed [qav_pkg::OUT_W-1:0] rate_z,
    output logic                            saturated,
    input  logic                            cfg_wr_en,
    input  logic [qav_pkg::CFG_W-1:0]       cfg_wr_data
);

    // ---------------------------------------------------------------------
    // widths
    // ---------------------------------------------------------------------
    localparam int A_W    = qav_pkg::IN_W + 1;          // a negated component
    localparam int PROD_W = 2 * A_W + 2;                // sum of four products
    localparam int SH     = 2 * QUAT_FRAC_BITS - 30;    // shift to q.30
    localparam int LSH    = (SH < 0) ? -SH : 0;
    localparam int RSH    = (SH > 0) ? SH : 0;
    localparam int MAG_W  = PROD_W + LSH + 1;           // q.30 magnitude
    localparam int W30_W  = 32;
    localparam int SQ_W   = 62;
    localparam int S_W    = 31;
    localparam int C_W    = 34;
    localparam int Z_W    = 34;
    localparam int ANG_W  = 34;
    localparam int M_W    = ANG_W + qav_pkg::CFG_W;
    localparam int D_W    = S_W + qav_pkg::CFG_W;
    localparam int ML     = (MAG_W + 1) / 2;
    localparam int MH     = MAG_W - ML;
    localparam int NL     = (M_W + 1) / 2;
    localparam int NH     = M_W - NL;
    localparam int P_W    = MAG_W + M_W;
    localparam int N_W    = P_W - qav_pkg::RATE_SHIFT;
    localparam int HI_W   = N_W - qav_pkg::DIV_N;
    localparam int CMP_W  = ((HI_W > D_W) ? HI_W : D_W) + 1;
    localparam int RND_SH = (RSH > 0) ? RSH - 1 : 0;
    localparam logic [MAG_W:0] RND_C = (RSH > 0) ? ((MAG_W + 1)'(1) << RND_SH) : '0;
    localparam logic [SQ_W-1:0] ONE60 = SQ_W'(1) << 60;

    // stages that carry a valid bit up to the final result register
    localparam int NSTG = 4 + qav_pkg::SQRT_N + qav_pkg::CORDIC_N + 4 + qav_pkg::DIV_N + 1;

    // ---------------------------------------------------------------------
    // types
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } comp_t;

    typedef struct packed {
        logic signed [A_W-1:0] ax, ay, az, aw;
        logic signed [A_W-1:0] bx, by, bz, bw;
        logic                  flip;
    } st1_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] dx, dy, dz, dw;
    } st2_t;

    typedef struct packed {
        logic signed [W30_W-1:0] w30;
        comp_t [2:0]             v;
    } st3_t;

    typedef struct packed {
        logic [60:0]             wsq;
        logic signed [W30_W-1:0] w30;
        comp_t [2:0]             v;
    } st4_t;

    typedef struct packed {
        logic [SQ_W-1:0]         rad;
        logic [SQ_W-1:0]         root;
        logic signed [W30_W-1:0] w30;
        comp_t [2:0]             v;
    } sq_t;

    typedef struct packed {
        logic signed [C_W-1:0] x, y;
        logic signed [Z_W-1:0] z;
        logic [S_W-1:0]        s30;
        comp_t [2:0]           v;
    } cd_t;

    typedef struct packed {
        logic [M_W-1:0] m;
        logic [D_W-1:0] d;
        logic           szero;
        comp_t [2:0]    v;
    } am_t;

    typedef struct packed {
        logic             neg;
        logic [ML+NL-1:0] p00;
        logic [ML+NH-1:0] p01;
        logic [MH+NL-1:0] p10;
        logic [MH+NH-1:0] p11;
    } ppc_t;

    typedef struct packed {
        ppc_t [2:0]     c;
        logic [D_W-1:0] d;
        logic           szero;
    } pp_t;

    typedef struct packed {
        logic           neg;
        logic [N_W-1:0] n;
    } nc_t;

    typedef struct packed {
        nc_t [2:0]      c;
        logic [D_W-1:0] d;
        logic           szero;
    } sm_t;

    typedef struct packed {
        logic                      neg;
        logic                      ovf;
        logic [D_W-1:0]            rem;
        logic [qav_pkg::DIV_N-1:0] nlo;
        logic [qav_pkg::DIV_N-1:0] q;
    } dvc_t;

    typedef struct packed {
        dvc_t [2:0]     c;
        logic [D_W-1:0] d;
        logic           szero;
    } dv_t;

    typedef struct packed {
        logic signed [qav_pkg::OUT_W-1:0] rx, ry, rz;
        logic                             sat;
    } res_t;

    // round half away from zero (or shift up) to a q.30 magnitude
    function automatic logic [MAG_W-1:0] q30_mag(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] pe;
        logic signed [PROD_W:0] pa;
        logic [MAG_W:0]         mag;
        pe  = {p[PROD_W-1], p};
        pa  = pe[PROD_W] ? -pe : pe;
        mag = (MAG_W + 1)'($unsigned(pa));
        mag = (mag + RND_C) >> RSH;
        mag = mag << LSH;
        return mag[MAG_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // flow control: the pipeline moves as one while the skid slot is empty
    // ---------------------------------------------------------------------
    logic            adv;
    logic [NSTG-1:0] vld_reg;
    res_t            out_reg;
    logic            out_vld_reg;
    res_t            skid_reg;
    logic            skid_vld_reg;
    res_t            fin_reg;
    res_t            fin_next;

    assign adv      = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    // sample period register
    logic [qav_pkg::CFG_W-1:0] period_reg;
    logic [qav_pkg::CFG_W-1:0] dt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= qav_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    // a zero period counts as one
    assign dt = (period_reg == '0) ? qav_pkg::CFG_W'(1) : period_reg;

    // valid bits walk alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: dot product decides the shortest-path flip
    // ---------------------------------------------------------------------
    logic signed [33:0] dot;
    st1_t               st1_reg;
    st1_t               st1_next;

    always_comb
    begin
        dot = 34'(first_x) * 34'(second_x) + 34'(first_y) * 34'(second_y)
            + 34'(first_z) * 34'(second_z) + 34'(first_w) * 34'(second_w);
        st1_next.ax   = A_W'(second_x);
        st1_next.ay   = A_W'(second_y);
        st1_next.az   = A_W'(second_z);
        st1_next.aw   = A_W'(second_w);
        // conjugate of the start quaternion
        st1_next.bx   = -A_W'(first_x);
        st1_next.by   = -A_W'(first_y);
        st1_next.bz   = -A_W'(first_z);
        st1_next.bw   = A_W'(first_w);
        st1_next.flip = force_shortest && dot[33];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg <= st1_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: hamilton product d = q2 * conj(q1)
    // ---------------------------------------------------------------------
    logic signed [A_W-1:0] ax, ay, az, aw;
    st2_t                  st2_reg;
    st2_t                  st2_next;

    always_comb
    begin
        ax = st1_reg.flip ? -st1_reg.ax : st1_reg.ax;
        ay = st1_reg.flip ? -st1_reg.ay : st1_reg.ay;
        az = st1_reg.flip ? -st1_reg.az : st1_reg.az;
        aw = st1_reg.flip ? -st1_reg.aw : st1_reg.aw;
        st2_next.dx = PROD_W'(aw) * PROD_W'(st1_reg.bx) + PROD_W'(ax) * PROD_W'(st1_reg.bw)
                    + PROD_W'(ay) * PROD_W'(st1_reg.bz) - PROD_W'(az) * PROD_W'(st1_reg.by);
        st2_next.dy = PROD_W'(aw) * PROD_W'(st1_reg.by) - PROD_W'(ax) * PROD_W'(st1_reg.bz)
                    + PROD_W'(ay) * PROD_W'(st1_reg.bw) + PROD_W'(az) * PROD_W'(st1_reg.bx);
        st2_next.dz = PROD_W'(aw) * PROD_W'(st1_reg.bz) + PROD_W'(ax) * PROD_W'(st1_reg.by)
                    - PROD_W'(ay) * PROD_W'(st1_reg.bx) + PROD_W'(az) * PROD_W'(st1_reg.bw);
        st2_next.dw = PROD_W'(aw) * PROD_W'(st1_reg.bw) - PROD_W'(ax) * PROD_W'(st1_reg.bx)
                    - PROD_W'(ay) * PROD_W'(st1_reg.by) - PROD_W'(az) * PROD_W'(st1_reg.bz);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st2_reg <= st2_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: move to q.30, clamp w to [-1, 1]
    // ---------------------------------------------------------------------
    logic [MAG_W-1:0]        wmag;
    logic [30:0]             wclamp;
    logic signed [W30_W-1:0] wpos;
    st3_t                    st3_reg;
    st3_t                    st3_next;

    always_comb
    begin
        wmag   = q30_mag(st2_reg.dw);
        wclamp = (wmag > MAG_W'(qav_pkg::ONE30)) ? qav_pkg::ONE30 : wmag[30:0];
        wpos   = W30_W'(wclamp);
        st3_next.w30      = st2_reg.dw[PROD_W-1] ? -wpos : wpos;
        st3_next.v[0].neg = st2_reg.dx[PROD_W-1];
        st3_next.v[0].mag = q30_mag(st2_reg.dx);
        st3_next.v[1].neg = st2_reg.dy[PROD_W-1];
        st3_next.v[1].mag = q30_mag(st2_reg.dy);
        st3_next.v[2].neg = st2_reg.dz[PROD_W-1];
        st3_next.v[2].mag = q30_mag(st2_reg.dz);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st3_reg <= st3_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 4: w squared
    // ---------------------------------------------------------------------
    logic signed [63:0] wsq_full;
    st4_t               st4_reg;
    st4_t               st4_next;

    always_comb
    begin
        wsq_full      = 64'(st3_reg.w30) * 64'(st3_reg.w30);
        st4_next.wsq  = wsq_full[60:0];
        st4_next.w30  = st3_reg.w30;
        st4_next.v    = st3_reg.v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st4_reg <= st4_next;
        end
    end

    // ---------------------------------------------------------------------
    // square root of 1 - w^2, one result bit per stage
    // ---------------------------------------------------------------------
    sq_t sq_init;
    sq_t sq_reg [qav_pkg::SQRT_N];

    always_comb
    begin
        sq_init.rad  = ONE60 - SQ_W'(st4_reg.wsq);
        sq_init.root = '0;
        sq_init.w30  = st4_reg.w30;
        sq_init.v    = st4_reg.v;
    end

    for (genvar k = 0; k < qav_pkg::SQRT_N; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] TB = SQ_W'(1) << (60 - 2 * k);
        sq_t             sq_in;
        sq_t             sq_next;
        logic [SQ_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign sq_in = sq_init;
        end
        else
        begin : g_rest
            assign sq_in = sq_reg[k-1];
        end

        always_comb
        begin
            trial   = sq_in.root + TB;
            sq_next = sq_in;
            if (sq_in.rad >= trial)
            begin
                sq_next.rad  = sq_in.rad - trial;
                sq_next.root = (sq_in.root >> 1) + TB;
            end
            else
            begin
                sq_next.root = sq_in.root >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[k] <= sq_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // cordic vectoring: half angle = atan2(s, w)
    // ---------------------------------------------------------------------
    cd_t                   cd_init;
    cd_t                   cd_reg [qav_pkg::CORDIC_N];
    logic [S_W-1:0]        s30;
    logic signed [C_W-1:0] x0;
    logic signed [C_W-1:0] y0;

    always_comb
    begin
        s30 = sq_reg[qav_pkg::SQRT_N-1].root[S_W-1:0];
        x0  = C_W'(sq_reg[qav_pkg::SQRT_N-1].w30);
        y0  = C_W'(s30);
        cd_init.s30 = s30;
        cd_init.v   = sq_reg[qav_pkg::SQRT_N-1].v;
        // left half plane: pre-rotate by -pi/2
        if (x0[C_W-1])
        begin
            cd_init.x = y0;
            cd_init.y = -x0;
            cd_init.z = Z_W'(qav_pkg::HALF_PI30);
        end
        else
        begin
            cd_init.x = x0;
            cd_init.y = y0;
            cd_init.z = '0;
        end
    end

    for (genvar i = 0; i < qav_pkg::CORDIC_N; i++)
    begin : g_cordic
        localparam logic signed [Z_W-1:0] AT = Z_W'(qav_pkg::ATAN_Q30[i]);
        cd_t                   cd_in;
        cd_t                   cd_next;
        logic signed [C_W-1:0] xs;
        logic signed [C_W-1:0] ys;

        if (i == 0)
        begin : g_first
            assign cd_in = cd_init;
        end
        else
        begin : g_rest
            assign cd_in = cd_reg[i-1];
        end

        always_comb
        begin
            xs      = cd_in.x >>> i;
            ys      = cd_in.y >>> i;
            cd_next = cd_in;
            if (!cd_in.y[C_W-1])
            begin
                cd_next.x = cd_in.x + ys;
                cd_next.y = cd_in.y - xs;
                cd_next.z = cd_in.z + AT;
            end
            else
            begin
                cd_next.x = cd_in.x - ys;
                cd_next.y = cd_in.y + xs;
                cd_next.z = cd_in.z - AT;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_reg[i] <= cd_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // angle * 1e6 and s * dt
    // ---------------------------------------------------------------------
    cd_t              cd_last;
    logic [ANG_W-1:0] ang;
    am_t              am_reg;
    am_t              am_next;

    always_comb
    begin
        cd_last = cd_reg[qav_pkg::CORDIC_N-1];
        ang     = cd_last.z[Z_W-1] ? '0 : ANG_W'({cd_last.z, 1'b0});
        am_next.m     = M_W'(ang) * M_W'(qav_pkg::RATE_SCALE);
        am_next.d     = D_W'(cd_last.s30) * D_W'(dt);
        am_next.szero = (cd_last.s30 == '0);
        am_next.v     = cd_last.v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            am_reg <= am_next;
        end
    end

    // ---------------------------------------------------------------------
    // |v| * m as four partial products per axis
    // ---------------------------------------------------------------------
    pp_t pp_reg;
    pp_t pp_next;

    always_comb
    begin
        pp_next.d     = am_reg.d;
        pp_next.szero = am_reg.szero;
        for (int c = 0; c < 3; c++)
        begin
            pp_next.c[c].neg = am_reg.v[c].neg;
            pp_next.c[c].p00 = (ML + NL)'(am_reg.v[c].mag[ML-1:0])
                             * (ML + NL)'(am_reg.m[NL-1:0]);
            pp_next.c[c].p01 = (ML + NH)'(am_reg.v[c].mag[ML-1:0])
                             * (ML + NH)'(am_reg.m[M_W-1:NL]);
            pp_next.c[c].p10 = (MH + NL)'(am_reg.v[c].mag[MAG_W-1:ML])
                             * (MH + NL)'(am_reg.m[NL-1:0]);
            pp_next.c[c].p11 = (MH + NH)'(am_reg.v[c].mag[MAG_W-1:ML])
                             * (MH + NH)'(am_reg.m[M_W-1:NL]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg <= pp_next;
        end
    end

    // ---------------------------------------------------------------------
    // sum partials, drop the alignment bits
    // ---------------------------------------------------------------------
    logic [P_W-1:0] psum [3];
    sm_t            sm_reg;
    sm_t            sm_next;

    always_comb
    begin
        sm_next.d     = pp_reg.d;
        sm_next.szero = pp_reg.szero;
        for (int c = 0; c < 3; c++)
        begin
            psum[c] = P_W'(pp_reg.c[c].p00)
                    + (P_W'(pp_reg.c[c].p01) << NL)
                    + (P_W'(pp_reg.c[c].p10) << ML)
                    + (P_W'(pp_reg.c[c].p11) << (ML + NL));
            sm_next.c[c].neg = pp_reg.c[c].neg;
            sm_next.c[c].n   = psum[c][P_W-1:qav_pkg::RATE_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_reg <= sm_next;
        end
    end

    // ---------------------------------------------------------------------
    // overflow check: unless s is zero, a quotient of 2^32 or more saturates
    // ---------------------------------------------------------------------
    logic [CMP_W-1:0] hix [3];
    dv_t              ck_reg;
    dv_t              ck_next;

    always_comb
    begin
        ck_next.d     = sm_reg.d;
        ck_next.szero = sm_reg.szero;
        for (int c = 0; c < 3; c++)
        begin
            hix[c] = CMP_W'(sm_reg.c[c].n[N_W-1:qav_pkg::DIV_N]);
            ck_next.c[c].neg = sm_reg.c[c].neg;
            ck_next.c[c].ovf = (hix[c] >= CMP_W'(sm_reg.d));
            ck_next.c[c].rem = hix[c][D_W-1:0];
            ck_next.c[c].nlo = sm_reg.c[c].n[qav_pkg::DIV_N-1:0];
            ck_next.c[c].q   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ck_reg <= ck_next;
        end
    end

    // ---------------------------------------------------------------------
    // restoring divide by s * dt, one quotient bit per stage
    // ---------------------------------------------------------------------
    dv_t dv_reg [qav_pkg::DIV_N];

    for (genvar j = 0; j < qav_pkg::DIV_N; j++)
    begin : g_div
        localparam int QB = qav_pkg::DIV_N - 1 - j;
        dv_t          dv_in;
        dv_t          dv_next;
        logic [D_W:0] rs   [3];
        logic [D_W:0] diff [3];

        if (j == 0)
        begin : g_first
            assign dv_in = ck_reg;
        end
        else
        begin : g_rest
            assign dv_in = dv_reg[j-1];
        end

        always_comb
        begin
            dv_next = dv_in;
            for (int c = 0; c < 3; c++)
            begin
                rs[c]   = {dv_in.c[c].rem, dv_in.c[c].nlo[QB]};
                diff[c] = rs[c] - {1'b0, dv_in.d};
                if (rs[c] >= {1'b0, dv_in.d})
                begin
                    dv_next.c[c].rem   = diff[c][D_W-1:0];
                    dv_next.c[c].q[QB] = 1'b1;
                end
                else
                begin
                    dv_next.c[c].rem = rs[c][D_W-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= dv_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // sign, saturation, zero axis
    // ---------------------------------------------------------------------
    dv_t                              dv_last;
    logic signed [qav_pkg::OUT_W-1:0] rv  [3];
    logic                             sat [3];

    always_comb
    begin
        dv_last = dv_reg[qav_pkg::DIV_N-1];
        for (int c = 0; c < 3; c++)
        begin
            sat[c] = 1'b0;
            if (dv_last.szero)
            begin
                rv[c] = '0;
            end
            else if (dv_last.c[c].ovf
                     || (!dv_last.c[c].neg && dv_last.c[c].q[31])
                     || (dv_last.c[c].neg && dv_last.c[c].q[31] && (|dv_last.c[c].q[30:0])))
            begin
                sat[c] = 1'b1;
                rv[c]  = dv_last.c[c].neg ? qav_pkg::RATE_MIN : qav_pkg::RATE_MAX;
            end
            else
            begin
                rv[c] = dv_last.c[c].neg ? -$signed(dv_last.c[c].q) : $signed(dv_last.c[c].q);
            end
        end
        fin_next.rx  = rv[0];
        fin_next.ry  = rv[1];
        fin_next.rz  = rv[2];
        fin_next.sat = sat[0] || sat[1] || sat[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_reg <= fin_next;
        end
    end

    // ---------------------------------------------------------------------
    // output register with skid slot
    // ---------------------------------------------------------------------
    logic fin_vld;
    logic out_free;

    assign fin_vld  = vld_reg[NSTG-1];
    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= fin_vld;
            end
        end
        else if (fin_vld)
        begin
            // output busy, park the word; adv is high here only if skid was empty
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_vld_reg ? skid_reg : fin_reg;
        end
        if (!out_free && !skid_vld_reg)
        begin
            skid_reg <= fin_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign rate_x    = out_reg.rx;
    assign rate_y    = out_reg.ry;
    assign rate_z    = out_reg.rz;
    assign saturated = out_reg.sat;

endmodule

// ===== rtl/qav_checker.sv =====
// qav_checker: port-level checks for quaternion_angular_velocity_unit, bound to the top level
// depends on qav_pkg (output limits)
module qav_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [qav_pkg::OUT_W-1:0] rate_x,
    input logic signed [qav_pkg::OUT_W-1:0] rate_y,
    input logic signed [qav_pkg::OUT_W-1:0] rate_z,
    input logic                             saturated
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rate_x) && $stable(rate_y)
            && $stable(rate_z) && $stable(saturated))
        else $error("stalled output word changed");

    // a saturated word carries at least one clipped rate
    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            rate_x == qav_pkg::RATE_MAX || rate_x == qav_pkg::RATE_MIN
            || rate_y == qav_pkg::RATE_MAX || rate_y == qav_pkg::RATE_MIN
            || rate_z == qav_pkg::RATE_MAX || rate_z == qav_pkg::RATE_MIN)
        else $error("saturated without a clipped rate");

    // input backpressure only while a word waits at the output
    a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // backpressure starts only after an output stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall raised without output stall");

endmodule

bind quaternion_angular_velocity_unit qav_checker u_qav_checker (.*);
